FILE: rtl/timer_min_heap_scheduler_macros.svh
// Assertion helpers used by the scheduler control RTL.
`ifndef TIMER_MIN_HEAP_SCHEDULER_MACROS_SVH
`define TIMER_MIN_HEAP_SCHEDULER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TMH_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define TMH_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler check failed");

`endif

FILE: rtl/tmh_pkg.sv
`default_nettype none
package tmh_pkg;

    localparam int TMH_HEAP_DEPTH = 64;
    localparam int TMH_MAX_FIRES  = 64;

    localparam int TIME_W = 48;
    localparam int ID_W   = 32;
    localparam int DLY_W  = 32;

    localparam logic [1:0] CMD_ADD  = 2'd0;
    localparam logic [1:0] CMD_DEL  = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;
    localparam logic [1:0] CMD_NOP  = 2'd3;

    localparam logic [1:0] EV_ADD  = 2'd0;
    localparam logic [1:0] EV_DEL  = 2'd1;
    localparam logic [1:0] EV_FIRE = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    typedef struct packed {
        logic [TIME_W-1:0] fire;
        logic [ID_W-1:0]   id;
        logic [DLY_W-1:0]  period;
    } entry_t;

    typedef struct packed {
        logic re;
        logic we;
    } mem_ctl_t;

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [DLY_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {{(TIME_W + 1 - DLY_W){1'b0}}, b};
        return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
    endfunction

    function automatic logic entry_before(input entry_t a, input entry_t b);
        return (a.fire < b.fire) || ((a.fire == b.fire) && (a.id < b.id));
    endfunction

endpackage
`default_nettype wire

FILE: rtl/tmh_if.sv
`default_nettype none
interface tmh_req_if import tmh_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        cmd;
    logic [TIME_W-1:0] now_ms;
    logic [DLY_W-1:0]  delay_ms;
    logic [DLY_W-1:0]  period_ms;
    logic [ID_W-1:0]   cancel_id;

    modport source (output valid, cmd, now_ms, delay_ms, period_ms, cancel_id,
                    input ready);
    modport sink   (input valid, cmd, now_ms, delay_ms, period_ms, cancel_id,
                    output ready);
endinterface

interface tmh_rsp_if import tmh_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [1:0]      event_kind;
    logic [ID_W-1:0] result_id;
    logic [1:0]      status;
    logic            last;

    modport source (output valid, event_kind, result_id, status, last, input ready);
    modport sink   (input valid, event_kind, result_id, status, last, output ready);
endinterface
`default_nettype wire

FILE: rtl/timer_min_heap_scheduler.sv
// Timer queue kept as a binary min-heap in one single-port-read synchronous
// memory, ordered by fire time and then id. Requests are taken one at a time
// (ready is high only when the block is idle) and the memory read port sets
// the rate: an add climbs the heap from the new leaf, a delete scans for the
// id entry by entry and then re-sifts the entry moved into the freed slot,
// and a tick pops each due timer and sifts the last entry down from the root,
// plus the re-arm climb for periodic timers. Results leave through a
// registered output stage; a tick emits each fired timer and marks the final
// one with last.
`default_nettype none
module timer_min_heap_scheduler import tmh_pkg::*; #(
    parameter int HEAP_DEPTH         = TMH_HEAP_DEPTH,
    parameter int MAX_FIRES_PER_TICK = TMH_MAX_FIRES
) (
    input  logic      clk,
    input  logic      rst_n,
    tmh_req_if.sink   req,
    tmh_rsp_if.source rsp
);

    localparam int AW = $clog2(HEAP_DEPTH);

    mem_ctl_t      mem_ctl;
    logic [AW-1:0] raddr;
    logic [AW-1:0] waddr;
    entry_t        wdata;
    entry_t        rdata;

    tmh_ctrl #(
        .HEAP_DEPTH         (HEAP_DEPTH),
        .MAX_FIRES_PER_TICK (MAX_FIRES_PER_TICK)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .mem_ctl (mem_ctl),
        .raddr   (raddr),
        .waddr   (waddr),
        .wdata   (wdata),
        .rdata   (rdata)
    );

    tmh_heap_ram #(
        .DEPTH (HEAP_DEPTH)
    ) u_ram (
        .clk   (clk),
        .ctl   (mem_ctl),
        .raddr (raddr),
        .waddr (waddr),
        .wdata (wdata),
        .rdata (rdata)
    );

endmodule
`default_nettype wire

FILE: rtl/tmh_heap_ram.sv
`default_nettype none
module tmh_heap_ram import tmh_pkg::*; #(
    parameter int DEPTH = TMH_HEAP_DEPTH
) (
    input  logic                     clk,
    input  mem_ctl_t                 ctl,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  entry_t                   wdata,
    output entry_t                   rdata
);

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[waddr] <= wdata;
        end
        if (ctl.re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

FILE: rtl/tmh_ctrl.sv
`default_nettype none
`include "timer_min_heap_scheduler_macros.svh"
module tmh_ctrl import tmh_pkg::*; #(
    parameter int HEAP_DEPTH         = TMH_HEAP_DEPTH,
    parameter int MAX_FIRES_PER_TICK = TMH_MAX_FIRES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    tmh_req_if.sink                       req,
    tmh_rsp_if.source                     rsp,
    output mem_ctl_t                      mem_ctl,
    output logic [$clog2(HEAP_DEPTH)-1:0] raddr,
    output logic [$clog2(HEAP_DEPTH)-1:0] waddr,
    output entry_t                        wdata,
    input  entry_t                        rdata
);

    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int CW = $clog2(HEAP_DEPTH + 1);
    localparam int LW = AW + 2;
    localparam int KW = $clog2(MAX_FIRES_PER_TICK + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_EMIT, S_UP, S_UP_CMP, S_DN, S_DN_R, S_DN_CMP,
        S_DEL_RD, S_DEL_CMP, S_DEL_LAST, S_TK_RD, S_TK_CHK, S_TK_EMIT,
        S_TK_LAST, S_TK_REARM
    } state_t;

    typedef enum logic [1:0] { OP_ADD, OP_DEL, OP_TICK } op_t;

    state_t            state_reg, state_next;
    op_t               op_reg, op_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [ID_W-1:0]   next_id_reg, next_id_next;
    logic              moved_reg, moved_next;
    logic [AW-1:0]     hole_reg, hole_next;
    logic [AW-1:0]     idx_reg, idx_next;
    entry_t            x_reg, x_next;
    entry_t            l_reg, l_next;
    entry_t            top_reg, top_next;
    logic [ID_W-1:0]   tid_reg, tid_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [KW-1:0]     k_reg, k_next;
    logic              pend_reg, pend_next;
    logic [ID_W-1:0]   pend_id_reg, pend_id_next;
    logic              due_reg, due_next;
    logic [1:0]        resp_kind_reg, resp_kind_next;
    logic [ID_W-1:0]   resp_id_reg, resp_id_next;
    logic [1:0]        resp_status_reg, resp_status_next;
    logic              out_valid_reg, out_valid_next;
    logic [1:0]        out_kind_reg, out_kind_next;
    logic [ID_W-1:0]   out_id_reg, out_id_next;
    logic [1:0]        out_status_reg, out_status_next;
    logic              out_last_reg, out_last_next;

    logic          out_free;
    logic          up_done;
    logic          dn_done;
    logic [AW-1:0] parent;
    logic [LW-1:0] lidx;
    logic [LW-1:0] ridx;
    logic [LW-1:0] cnt_ext;
    logic          r_ok;
    logic          pick_l;
    logic          pick_r;
    entry_t        cand;
    logic [CW-1:0] cnt_dec;

    assign out_free = !out_valid_reg || rsp.ready;
    assign parent   = (hole_reg - AW'(1)) >> 1;
    assign lidx     = {1'b0, hole_reg, 1'b1};
    assign ridx     = {1'b0, hole_reg, 1'b0} + LW'(2);
    assign cnt_ext  = LW'(count_reg);
    assign r_ok     = ridx < cnt_ext;
    assign pick_l   = entry_before(l_reg, x_reg);
    assign cand     = pick_l ? l_reg : x_reg;
    assign pick_r   = r_ok && entry_before(rdata, cand);
    assign cnt_dec  = count_reg - CW'(1);

    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.event_kind = out_kind_reg;
    assign rsp.result_id  = out_id_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.last       = out_last_reg;

    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        count_next       = count_reg;
        next_id_next     = next_id_reg;
        moved_next       = moved_reg;
        hole_next        = hole_reg;
        idx_next         = idx_reg;
        x_next           = x_reg;
        l_next           = l_reg;
        top_next         = top_reg;
        tid_next         = tid_reg;
        now_next         = now_reg;
        k_next           = k_reg;
        pend_next        = pend_reg;
        pend_id_next     = pend_id_reg;
        due_next         = due_reg;
        resp_kind_next   = resp_kind_reg;
        resp_id_next     = resp_id_reg;
        resp_status_next = resp_status_reg;
        out_valid_next   = rsp.ready ? 1'b0 : out_valid_reg;
        out_kind_next    = out_kind_reg;
        out_id_next      = out_id_reg;
        out_status_next  = out_status_reg;
        out_last_next    = out_last_reg;
        mem_ctl          = '0;
        raddr            = '0;
        waddr            = hole_reg;
        wdata            = x_reg;
        up_done          = 1'b0;
        dn_done          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    case (req.cmd)
                        CMD_ADD:
                        begin
                            next_id_next = next_id_reg + ID_W'(1);
                            if (count_reg >= CW'(HEAP_DEPTH))
                            begin
                                resp_kind_next   = EV_ADD;
                                resp_id_next     = '0;
                                resp_status_next = ST_FULL;
                                state_next       = S_EMIT;
                            end
                            else
                            begin
                                x_next.fire   = sat_add(req.now_ms, req.delay_ms);
                                x_next.id     = next_id_reg + ID_W'(1);
                                x_next.period = req.period_ms;
                                hole_next     = count_reg[AW-1:0];
                                count_next    = count_reg + CW'(1);
                                op_next       = OP_ADD;
                                moved_next    = 1'b0;
                                state_next    = S_UP;
                            end
                        end
                        CMD_DEL:
                        begin
                            tid_next = req.cancel_id;
                            idx_next = '0;
                            if (count_reg == '0)
                            begin
                                resp_kind_next   = EV_DEL;
                                resp_id_next     = '0;
                                resp_status_next = ST_NOTFOUND;
                                state_next       = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_DEL_RD;
                            end
                        end
                        CMD_TICK:
                        begin
                            now_next   = req.now_ms;
                            k_next     = '0;
                            pend_next  = 1'b0;
                            state_next = S_TK_RD;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = resp_kind_reg;
                    out_id_next     = resp_id_reg;
                    out_status_next = resp_status_reg;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_UP:
            begin
                if (hole_reg == '0)
                begin
                    up_done = 1'b1;
                end
                else
                begin
                    mem_ctl.re = 1'b1;
                    raddr      = parent;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                if (entry_before(x_reg, rdata))
                begin
                    // move the parent down into the hole
                    mem_ctl.we = 1'b1;
                    wdata      = rdata;
                    hole_next  = parent;
                    moved_next = 1'b1;
                    state_next = S_UP;
                end
                else
                begin
                    up_done = 1'b1;
                end
            end
            S_DN:
            begin
                if (lidx >= cnt_ext)
                begin
                    dn_done = 1'b1;
                end
                else
                begin
                    mem_ctl.re = 1'b1;
                    raddr      = lidx[AW-1:0];
                    state_next = S_DN_R;
                end
            end
            S_DN_R:
            begin
                l_next = rdata;
                if (r_ok)
                begin
                    mem_ctl.re = 1'b1;
                    raddr      = ridx[AW-1:0];
                end
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                if (pick_r)
                begin
                    mem_ctl.we = 1'b1;
                    wdata      = rdata;
                    hole_next  = ridx[AW-1:0];
                    state_next = S_DN;
                end
                else if (pick_l)
                begin
                    mem_ctl.we = 1'b1;
                    wdata      = l_reg;
                    hole_next  = lidx[AW-1:0];
                    state_next = S_DN;
                end
                else
                begin
                    dn_done = 1'b1;
                end
            end
            S_DEL_RD:
            begin
                mem_ctl.re = 1'b1;
                raddr      = idx_reg;
                state_next = S_DEL_CMP;
            end
            S_DEL_CMP:
            begin
                if (rdata.id == tid_reg)
                begin
                    count_next = cnt_dec;
                    if (CW'(idx_reg) < cnt_dec)
                    begin
                        // pull the last entry into the freed slot
                        mem_ctl.re = 1'b1;
                        raddr      = cnt_dec[AW-1:0];
                        state_next = S_DEL_LAST;
                    end
                    else
                    begin
                        resp_kind_next   = EV_DEL;
                        resp_id_next     = tid_reg;
                        resp_status_next = ST_OK;
                        state_next       = S_EMIT;
                    end
                end
                else if (CW'(idx_reg) + CW'(1) >= count_reg)
                begin
                    resp_kind_next   = EV_DEL;
                    resp_id_next     = '0;
                    resp_status_next = ST_NOTFOUND;
                    state_next       = S_EMIT;
                end
                else
                begin
                    idx_next   = idx_reg + AW'(1);
                    state_next = S_DEL_RD;
                end
            end
            S_DEL_LAST:
            begin
                x_next     = rdata;
                hole_next  = idx_reg;
                moved_next = 1'b0;
                op_next    = OP_DEL;
                state_next = S_UP;
            end
            S_TK_RD:
            begin
                if ((k_reg < KW'(MAX_FIRES_PER_TICK)) && (count_reg != '0))
                begin
                    mem_ctl.re = 1'b1;
                    raddr      = '0;
                    state_next = S_TK_CHK;
                end
                else
                begin
                    due_next   = 1'b0;
                    state_next = S_TK_EMIT;
                end
            end
            S_TK_CHK:
            begin
                top_next   = rdata;
                due_next   = (rdata.fire <= now_reg);
                state_next = S_TK_EMIT;
            end
            S_TK_EMIT:
            begin
                // hold the previous fire until we know whether it ends the tick
                if (!pend_reg || out_free)
                begin
                    if (pend_reg)
                    begin
                        out_valid_next  = 1'b1;
                        out_kind_next   = EV_FIRE;
                        out_id_next     = pend_id_reg;
                        out_status_next = ST_OK;
                        out_last_next   = !due_reg;
                    end
                    if (!due_reg)
                    begin
                        pend_next  = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        pend_next    = 1'b1;
                        pend_id_next = top_reg.id;
                        k_next       = k_reg + KW'(1);
                        count_next   = cnt_dec;
                        if (cnt_dec != '0)
                        begin
                            mem_ctl.re = 1'b1;
                            raddr      = cnt_dec[AW-1:0];
                            state_next = S_TK_LAST;
                        end
                        else
                        begin
                            state_next = S_TK_REARM;
                        end
                    end
                end
            end
            S_TK_LAST:
            begin
                x_next     = rdata;
                hole_next  = '0;
                op_next    = OP_TICK;
                state_next = S_DN;
            end
            S_TK_REARM:
            begin
                if (top_reg.period != '0)
                begin
                    x_next.fire   = sat_add(top_reg.fire, top_reg.period);
                    x_next.id     = top_reg.id;
                    x_next.period = top_reg.period;
                    hole_next     = count_reg[AW-1:0];
                    count_next    = count_reg + CW'(1);
                    op_next       = OP_TICK;
                    moved_next    = 1'b0;
                    state_next    = S_UP;
                end
                else
                begin
                    state_next = S_TK_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (up_done)
        begin
            if ((op_reg == OP_DEL) && !moved_reg)
            begin
                // replacement did not rise: sift it down from the same slot
                state_next = S_DN;
            end
            else
            begin
                mem_ctl.we = 1'b1;
                wdata      = x_reg;
                case (op_reg)
                    OP_ADD:
                    begin
                        resp_kind_next   = EV_ADD;
                        resp_id_next     = x_reg.id;
                        resp_status_next = ST_OK;
                        state_next       = S_EMIT;
                    end
                    OP_DEL:
                    begin
                        resp_kind_next   = EV_DEL;
                        resp_id_next     = tid_reg;
                        resp_status_next = ST_OK;
                        state_next       = S_EMIT;
                    end
                    default:
                    begin
                        state_next = S_TK_RD;
                    end
                endcase
            end
        end

        if (dn_done)
        begin
            mem_ctl.we = 1'b1;
            wdata      = x_reg;
            if (op_reg == OP_DEL)
            begin
                resp_kind_next   = EV_DEL;
                resp_id_next     = tid_reg;
                resp_status_next = ST_OK;
                state_next       = S_EMIT;
            end
            else
            begin
                state_next = S_TK_REARM;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_ADD;
            count_reg     <= '0;
            next_id_reg   <= '0;
            moved_reg     <= 1'b0;
            k_reg         <= '0;
            pend_reg      <= 1'b0;
            due_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            count_reg     <= count_next;
            next_id_reg   <= next_id_next;
            moved_reg     <= moved_next;
            k_reg         <= k_next;
            pend_reg      <= pend_next;
            due_reg       <= due_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hole_reg        <= hole_next;
        idx_reg         <= idx_next;
        x_reg           <= x_next;
        l_reg           <= l_next;
        top_reg         <= top_next;
        tid_reg         <= tid_next;
        now_reg         <= now_next;
        pend_id_reg     <= pend_id_next;
        resp_kind_reg   <= resp_kind_next;
        resp_id_reg     <= resp_id_next;
        resp_status_reg <= resp_status_next;
        out_kind_reg    <= out_kind_next;
        out_id_reg      <= out_id_next;
        out_status_reg  <= out_status_next;
        out_last_reg    <= out_last_next;
    end

    `TMH_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CW'(HEAP_DEPTH))
    `TMH_ASSERT_IMP(a_fire_bound, 1'b1, k_reg <= KW'(MAX_FIRES_PER_TICK))
    `TMH_ASSERT_IMP(a_no_rw_clash, mem_ctl.re && mem_ctl.we, raddr != waddr)
    `TMH_ASSERT_NXT(a_busy_after_cmd, req.valid && req.ready && (req.cmd != CMD_NOP), !req.ready)

endmodule
`default_nettype wire
